// ===== src/c3es_pkg.sv =====
// c3es_pkg: shared types, register indexes and reset values for the 3x3
// convolution filter. No dependencies; imported by the interfaces and the top level.
`default_nettype none

package c3es_pkg;

   // Pixel, result, coordinate and register field widths, fixed by the stream format
   localparam int PIXEL_BITS    = 8;
   localparam int FILTERED_BITS = 12;
   localparam int COORD_BITS    = 10;
   localparam int CSR_DATA_BITS = 11;
   localparam int CSR_INDEX_BITS = 2;

   typedef logic [PIXEL_BITS-1:0]            pixel_type;
   typedef logic signed [FILTERED_BITS-1:0]  filtered_type;
   typedef logic [COORD_BITS-1:0]            coord_type;
   typedef logic [CSR_DATA_BITS-1:0]         csr_data_type;
   typedef logic [CSR_INDEX_BITS-1:0]        csr_index_type;

   // Register indexes
   localparam csr_index_type CSR_FRAME_WIDTH   = 2'd0;
   localparam csr_index_type CSR_FRAME_HEIGHT  = 2'd1;
   localparam csr_index_type CSR_KERNEL_SELECT = 2'd2;

   // Register reset values
   localparam csr_data_type FRAME_WIDTH_RESET  = 11'd640;
   localparam csr_data_type FRAME_HEIGHT_RESET = 11'd480;

   // Kernel codes
   localparam logic KERNEL_LAPLACIAN = 1'b0;
   localparam logic KERNEL_SHARPEN   = 1'b1;

   // Smallest frame dimension the window can work on
   localparam int MIN_SIZE = 3;

endpackage : c3es_pkg

`default_nettype wire

// ===== src/c3es_if.sv =====
// c3es_if: valid/ready channel interfaces for the pixel input, the filtered
// result output and the register write port. Depends on c3es_pkg.
`default_nettype none

interface c3es_req_if;
   import c3es_pkg::*;
   logic      valid;
   logic      ready;
   pixel_type pixel;
   logic      frame_start;

   modport source (output valid, output pixel, output frame_start, input ready);
   modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface : c3es_req_if

interface c3es_rsp_if;
   import c3es_pkg::*;
   logic         valid;
   logic         ready;
   filtered_type filtered;
   coord_type    centre_col;
   coord_type    centre_row;
   logic         frame_last;

   modport source (output valid, output filtered, output centre_col,
                   output centre_row, output frame_last, input ready);
   modport sink   (input valid, input filtered, input centre_col,
                   input centre_row, input frame_last, output ready);
endinterface : c3es_rsp_if

interface c3es_csr_if;
   import c3es_pkg::*;
   logic          valid;
   logic          ready;
   csr_index_type index;
   csr_data_type  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface : c3es_csr_if

`default_nettype wire

// ===== src/conv3x3_edge_sharpen_filter_top.sv =====
// conv3x3_edge_sharpen_filter_top: 3x3 Laplacian / sharpen filter on a raster pixel stream.
// A result passes the read stage (line store read), then the window update and sum into the
// output register. Throughput: one pixel per clock unless a held result stalls the read stage;
// set by the line store read-modify-write (one read and one write port per store each cycle).
// Reset: synchronous, active high; clears position, window and valid flags, loads register reset
// values. Line stores are not cleared and need no clearing pass. Depends on c3es_pkg, c3es_if.
`default_nettype none

module conv3x3_edge_sharpen_filter_top #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  wire logic   clock,
   input  wire logic   reset,
   c3es_req_if.sink    req_chan,
   c3es_rsp_if.source  rsp_chan,
   c3es_csr_if.sink    csr_chan
);
   import c3es_pkg::*;

   localparam int CW  = $clog2(MAX_WIDTH);    // column index bits
   localparam int RW  = $clog2(MAX_HEIGHT);   // row index bits
   localparam int WHW = CW + 1;               // width value bits
   localparam int RHW = RW + 1;               // height value bits

   // Configuration registers
   csr_data_type width_cfg_ff;
   csr_data_type height_cfg_ff;
   logic         kernel_ff;

   // Position of the next incoming pixel
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   // Line stores and their registered read data
   pixel_type older_mem [MAX_WIDTH];
   pixel_type newer_mem [MAX_WIDTH];
   pixel_type rd_older_ff, rd_newer_ff;

   // Forwarding of the last write-back
   pixel_type fwd_older_ff, fwd_newer_ff;
   logic      bypass_ff;

   // Read stage
   logic          s1_valid_ff;
   logic [CW-1:0] s1_col_ff;
   logic [RW-1:0] s1_row_ff;
   pixel_type     s1_pixel_ff;
   logic          s1_produce_ff;
   logic          s1_last_ff;

   // Window, [row 0 oldest][col 0 oldest]
   pixel_type win_ff [3][3];

   // Output register
   logic         rsp_valid_ff;
   filtered_type rsp_filtered_ff;
   coord_type    rsp_col_ff;
   coord_type    rsp_row_ff;
   logic         rsp_last_ff;

   logic [WHW-1:0] w_eff;
   logic [RHW-1:0] h_eff;
   logic [CW-1:0]  pos_col;
   logic [RW-1:0]  pos_row;
   logic [RHW-1:0] row_a, row_b;
   logic [CW-1:0]  col_a;
   logic [WHW-1:0] col_next;
   logic [RHW-1:0] row_next;
   logic           pos_produce, pos_last;
   logic           req_acc, s1_adv;
   pixel_type      res_older, res_newer;
   logic [10:0]    nb8_sum;
   logic [9:0]     nb4_sum;
   logic signed [12:0] lap_sum, sharp_sum, sel_sum;

   // Clamp frame size into the supported range
   always_comb begin
      if (width_cfg_ff < CSR_DATA_BITS'(MIN_SIZE)) begin
         w_eff = WHW'(MIN_SIZE);
      end else if (32'(width_cfg_ff) > 32'(MAX_WIDTH)) begin
         w_eff = WHW'(MAX_WIDTH);
      end else begin
         w_eff = WHW'(width_cfg_ff);
      end
      if (height_cfg_ff < CSR_DATA_BITS'(MIN_SIZE)) begin
         h_eff = RHW'(MIN_SIZE);
      end else if (32'(height_cfg_ff) > 32'(MAX_HEIGHT)) begin
         h_eff = RHW'(MAX_HEIGHT);
      end else begin
         h_eff = RHW'(height_cfg_ff);
      end
   end

   // Register writes
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_cfg_ff  <= FRAME_WIDTH_RESET;
         height_cfg_ff <= FRAME_HEIGHT_RESET;
         kernel_ff     <= KERNEL_LAPLACIAN;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_FRAME_WIDTH:   width_cfg_ff  <= csr_chan.data;
            CSR_FRAME_HEIGHT:  height_cfg_ff <= csr_chan.data;
            CSR_KERNEL_SELECT: kernel_ff     <= csr_chan.data[0];
            default: ;
         endcase
      end
   end

   // Handshake: the read stage moves on when the output slot is free or unused
   assign s1_adv  = s1_valid_ff && (!s1_produce_ff || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_adv;
   assign req_acc = req_chan.valid && req_chan.ready;

   // Resolve the position of the incoming pixel and the one after it
   always_comb begin
      col_a = req_chan.frame_start ? '0 : col_ff;
      row_a = req_chan.frame_start ? '0 : RHW'(row_ff);
      if (WHW'(col_a) >= w_eff) begin
         col_a = '0;
         row_a = row_a + RHW'(1);
      end
      row_b = (row_a >= h_eff) ? '0 : row_a;
      pos_col = col_a;
      pos_row = RW'(row_b);

      pos_produce = (row_b >= RHW'(2)) && (col_a >= CW'(2));
      pos_last    = (row_b == h_eff - RHW'(1)) && (WHW'(col_a) == w_eff - WHW'(1));

      col_next = WHW'(pos_col) + WHW'(1);
      row_next = RHW'(pos_row);
      if (col_next >= w_eff) begin
         col_next = '0;
         row_next = row_next + RHW'(1);
         if (row_next >= h_eff) begin
            row_next = '0;
         end
      end
      col_in = CW'(col_next);
      row_in = RW'(row_next);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_acc) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Read stage: capture the transaction and the line store data
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         bypass_ff   <= 1'b0;
      end else if (req_acc) begin
         s1_valid_ff <= 1'b1;
         bypass_ff   <= s1_adv && (pos_col == s1_col_ff);
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_col_ff     <= pos_col;
         s1_row_ff     <= pos_row;
         s1_pixel_ff   <= req_chan.pixel;
         s1_produce_ff <= pos_produce;
         s1_last_ff    <= pos_last;
      end
   end

   // Take forwarded data when the previous transaction wrote the same column
   assign res_older = bypass_ff ? fwd_older_ff : rd_older_ff;
   assign res_newer = bypass_ff ? fwd_newer_ff : rd_newer_ff;

   // Line store read and write-back
   always_ff @(posedge clock) begin
      if (req_acc) begin
         rd_older_ff <= older_mem[pos_col];
         rd_newer_ff <= newer_mem[pos_col];
      end
      if (s1_adv) begin
         older_mem[s1_col_ff] <= res_newer;
         newer_mem[s1_col_ff] <= s1_pixel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         fwd_older_ff <= res_newer;
         fwd_newer_ff <= s1_pixel_ff;
      end
   end

   // Shift the window left and insert the new column
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[k][j] <= '0;
            end
         end
      end else if (s1_adv) begin
         for (int k = 0; k < 3; k++) begin
            win_ff[k][0] <= win_ff[k][1];
            win_ff[k][1] <= win_ff[k][2];
         end
         win_ff[0][2] <= res_older;
         win_ff[1][2] <= res_newer;
         win_ff[2][2] <= s1_pixel_ff;
      end
   end

   // Kernel sums over the shifted window; centre is the old middle-right pixel
   always_comb begin
      nb4_sum = 10'(win_ff[0][2]) + 10'(win_ff[2][2]) + 10'(win_ff[1][1])
              + 10'(res_newer);
      nb8_sum = 11'(nb4_sum) + 11'(win_ff[0][1]) + 11'(win_ff[2][1])
              + 11'(res_older) + 11'(s1_pixel_ff);
      lap_sum   = $signed({2'b00, win_ff[1][2], 3'b000}) - $signed({2'b00, nb8_sum});
      sharp_sum = $signed({3'b000, win_ff[1][2], 2'b00}) + $signed({5'b00000, win_ff[1][2]})
                - $signed({3'b000, nb4_sum});
      sel_sum   = (kernel_ff == KERNEL_SHARPEN) ? sharp_sum : lap_sum;
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv && s1_produce_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_produce_ff) begin
         rsp_filtered_ff <= sel_sum[FILTERED_BITS-1:0];
         rsp_col_ff      <= COORD_BITS'(s1_col_ff - CW'(1));
         rsp_row_ff      <= COORD_BITS'(s1_row_ff - RW'(1));
         rsp_last_ff     <= s1_last_ff;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.filtered   = rsp_filtered_ff;
   assign rsp_chan.centre_col = rsp_col_ff;
   assign rsp_chan.centre_row = rsp_row_ff;
   assign rsp_chan.frame_last = rsp_last_ff;

endmodule : conv3x3_edge_sharpen_filter_top

`default_nettype wire

// ===== verif/tb_conv3x3_edge_sharpen_filter_top.sv =====
// tb_conv3x3_edge_sharpen_filter_top: self-checking bench for the 3x3 Laplacian / sharpen
// filter; streams pixels, predicts each interior sum with its coordinates and checks them.
// Depends on c3es_pkg, c3es_if and conv3x3_edge_sharpen_filter_top.
`default_nettype none

module tb_conv3x3_edge_sharpen_filter_top;
   timeunit 1ns;
   timeprecision 1ps;

   import c3es_pkg::*;

   localparam int MAX_WIDTH       = 1024;
   localparam int MAX_HEIGHT      = 1024;
   localparam int DRAIN_CYCLES    = 8;
   localparam int STALL_LIMIT     = 2000;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int WIDE_PIXELS     = 48;
   localparam int FILL_WIDTH      = 40;   // widest frame the random phases pick
   localparam int FILL_HEIGHT     = 8;
   localparam int RANDOM_PIXELS   = 1350;
   localparam int QUIET_TAIL_FROM = 1100;

   typedef struct packed {
      pixel_type value;
      logic      frame_start;
   } pixel_item_type;

   typedef struct {
      filtered_type filtered;
      coord_type    centre_col;
      coord_type    centre_row;
      logic         frame_last;
   } filter_sum_type;

   logic clock;
   logic reset;

   c3es_req_if pixel_if ();
   c3es_rsp_if result_if ();
   c3es_csr_if csr_if ();

   conv3x3_edge_sharpen_filter_top #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (pixel_if),
      .rsp_chan (result_if),
      .csr_chan (csr_if)
   );

   // Stream queues and run status
   pixel_item_type pixels_to_send [$];
   filter_sum_type sums_in_flight [$];
   int          mismatch_count;
   int          quiet_cycles;
   bit          pixel_taken;
   int          send_gap;
   int          take_gap;
   int          send_gap_pct;
   int          take_gap_pct;
   bit          pressure_armed;
   bit          hold_results;

   // Predictor state: registers, line stores, window and raster position
   csr_data_type frame_width_reg;
   csr_data_type frame_height_reg;
   logic         kernel_reg;
   pixel_type    older_row [MAX_WIDTH];
   pixel_type    newer_row [MAX_WIDTH];
   pixel_type    window [3][3];
   int unsigned  col_pos;
   int unsigned  row_pos;

   // Generator's view of the active frame size
   int unsigned  gen_width;
   int unsigned  gen_height;
   int           random_pixel_count;

   initial begin : clock_gen
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int unsigned clamp_dim(input csr_data_type v, input int unsigned top);
      if (v < MIN_SIZE) return MIN_SIZE;
      if (v > top) return top;
      return v;
   endfunction

   // Advance the raster position for one pixel and queue the sum it completes, if any
   task automatic convolve_pixel(input pixel_type px, input logic restart);
      int unsigned w, h, c, r;
      int          all_sum;
      int          sum;
      filter_sum_type res;
      w = clamp_dim(frame_width_reg, MAX_WIDTH);
      h = clamp_dim(frame_height_reg, MAX_HEIGHT);
      if (restart) begin
         col_pos = 0;
         row_pos = 0;
      end
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
      c = col_pos;
      r = row_pos;

      // shift the window left and load the new column from the line stores
      for (int k = 0; k < 3; k++) begin
         window[k][0] = window[k][1];
         window[k][1] = window[k][2];
      end
      window[0][2] = older_row[c];
      window[1][2] = newer_row[c];
      window[2][2] = px;
      older_row[c] = newer_row[c];
      newer_row[c] = px;

      if (r >= 2 && c >= 2) begin
         if (kernel_reg == KERNEL_LAPLACIAN) begin
            all_sum = 0;
            for (int i = 0; i < 3; i++)
               for (int j = 0; j < 3; j++)
                  all_sum += int'(window[i][j]);
            sum = 9 * int'(window[1][1]) - all_sum;
         end else begin
            sum = 5 * int'(window[1][1]) - int'(window[0][1]) - int'(window[2][1])
                  - int'(window[1][0]) - int'(window[1][2]);
         end
         res.filtered   = filtered_type'(sum);
         res.centre_col = coord_type'(c - 1);
         res.centre_row = coord_type'(r - 1);
         res.frame_last = (r == h - 1) && (c == w - 1);
         sums_in_flight.push_back(res);
      end

      col_pos = c + 1;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos = r + 1;
         if (row_pos >= h) row_pos = 0;
      end
   endtask

   // Track accepted transactions on the pixel and register ports
   always @(posedge clock) begin : transaction_tracker
      pixel_taken <= pixel_if.valid && pixel_if.ready;
      if (reset) begin
         frame_width_reg  = FRAME_WIDTH_RESET;
         frame_height_reg = FRAME_HEIGHT_RESET;
         kernel_reg       = KERNEL_LAPLACIAN;
         window           = '{default: '0};
         col_pos          = 0;
         row_pos          = 0;
      end else begin
         if (csr_if.valid && csr_if.ready) begin
            unique case (csr_if.index)
               CSR_FRAME_WIDTH:   frame_width_reg  = csr_if.data;
               CSR_FRAME_HEIGHT:  frame_height_reg = csr_if.data;
               CSR_KERNEL_SELECT: kernel_reg       = csr_if.data[0];
               default: ;
            endcase
         end
         if (pixel_if.valid && pixel_if.ready)
            convolve_pixel(pixel_if.pixel, pixel_if.frame_start);
      end
   end

   // Offer queued pixels; hold each one until its transaction completes
   always @(negedge clock) begin : pixel_driver
      bit offer;
      if (pixel_taken) pixels_to_send.delete(0);
      offer = pixel_if.valid && !pixel_taken;
      if (!offer) begin
         if (send_gap > 0)
            send_gap--;
         else if (pixels_to_send.size() != 0 && send_gap_pct != 0 &&
                  $urandom_range(99) < send_gap_pct)
            send_gap = $urandom_range(16, 0);
         else if (pixels_to_send.size() != 0)
            offer = 1'b1;
      end
      pixel_if.valid <= offer;
      if (offer) begin
         pixel_if.pixel       <= pixels_to_send[0].value;
         pixel_if.frame_start <= pixels_to_send[0].frame_start;
      end
   end

   // Drop ready in random bursts, or for the long hold-off
   always @(negedge clock) begin : result_ready_driver
      bit take;
      take = 1'b0;
      if (!hold_results) begin
         if (take_gap > 0)
            take_gap--;
         else if (take_gap_pct != 0 && $urandom_range(99) < take_gap_pct)
            take_gap = $urandom_range(16, 0);
         else
            take = 1'b1;
      end
      result_if.ready <= take;
   end

   // Compare each result transaction with the oldest predicted sum
   always @(posedge clock) begin : result_monitor
      filter_sum_type want;
      if (!reset && result_if.valid && result_if.ready) begin
         if (sums_in_flight.size() == 0) begin
            $error("result with none predicted: filtered %0d col %0d row %0d",
                   result_if.filtered, result_if.centre_col, result_if.centre_row);
            mismatch_count++;
         end else begin
            want = sums_in_flight.pop_front();
            if (result_if.filtered !== want.filtered) begin
               $error("filtered: expected %0d, got %0d", want.filtered, result_if.filtered);
               mismatch_count++;
            end
            if (result_if.centre_col !== want.centre_col) begin
               $error("centre_col: expected %0d, got %0d",
                      want.centre_col, result_if.centre_col);
               mismatch_count++;
            end
            if (result_if.centre_row !== want.centre_row) begin
               $error("centre_row: expected %0d, got %0d",
                      want.centre_row, result_if.centre_row);
               mismatch_count++;
            end
            if (result_if.frame_last !== want.frame_last) begin
               $error("frame_last: expected %0b, got %0b",
                      want.frame_last, result_if.frame_last);
               mismatch_count++;
            end
         end
      end
   end

   // End the run when no transaction of any kind completes for too long
   always @(posedge clock) begin : watchdog
      if (reset || (pixel_if.valid && pixel_if.ready) || (result_if.valid && result_if.ready)
          || (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Hold off the receiver once, while the sender keeps offering pixels
   initial begin : receiver_hold_off
      while (!pressure_armed) @(posedge clock);
      @(posedge clock);
      hold_results <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
      hold_results <= 1'b0;
   end

   task automatic queue_pixel(input pixel_type value, input logic frame_start);
      pixel_item_type item;
      item.value       = value;
      item.frame_start = frame_start;
      pixels_to_send.push_back(item);
   endtask

   // Queue one 3x3 frame: centre, direct neighbors and corners each get one value
   task automatic queue_window(input pixel_type centre, input pixel_type direct,
                               input pixel_type corner, input logic frame_start);
      queue_pixel(corner, frame_start);
      queue_pixel(direct, 1'b0);
      queue_pixel(corner, 1'b0);
      queue_pixel(direct, 1'b0);
      queue_pixel(centre, 1'b0);
      queue_pixel(direct, 1'b0);
      queue_pixel(corner, 1'b0);
      queue_pixel(direct, 1'b0);
      queue_pixel(corner, 1'b0);
   endtask

   // Wait until every pixel is sent and every sum is back, then let the pipeline empty
   task automatic drain_stream();
      while (pixels_to_send.size() != 0 || sums_in_flight.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write the selected registers back to back on the register port
   task automatic program_registers(input logic [2:0] sel, input csr_data_type width_val,
                                    input csr_data_type height_val, input logic kernel_val);
      csr_index_type reg_index [3];
      csr_data_type  reg_value [3];
      reg_index = '{CSR_FRAME_WIDTH, CSR_FRAME_HEIGHT, CSR_KERNEL_SELECT};
      reg_value = '{width_val, height_val, csr_data_type'(kernel_val)};
      for (int i = 0; i < 3; i++) begin
         if (sel[i]) begin
            @(negedge clock);
            csr_if.valid <= 1'b1;
            csr_if.index <= reg_index[i];
            csr_if.data  <= reg_value[i];
            do @(posedge clock); while (!csr_if.ready);
         end
      end
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   function automatic pixel_type styled_pixel(input int style, input pixel_type base);
      unique case (style)
         0:       return pixel_type'($urandom_range(255));
         1:       return $urandom_range(1) ? 8'hFF : 8'h00;
         default: return pixel_type'(base + $urandom_range(15));
      endcase
   endfunction

   // Queue one to three frames of the current size; some are cut short or restarted
   task automatic queue_random_frames();
      int unsigned full, len;
      int          style;
      logic        fs_first;
      pixel_type   base;
      for (int f = $urandom_range(3, 1); f > 0; f--) begin
         full     = gen_width * gen_height;
         len      = ($urandom_range(99) < 80) ? full : $urandom_range(full, 1);
         fs_first = ($urandom_range(99) < 75);
         style    = $urandom_range(2);
         base     = pixel_type'($urandom_range(240));
         for (int unsigned i = 0; i < len; i++) begin
            queue_pixel(styled_pixel(style, base),
                        (i == 0 && fs_first) || $urandom_range(199) == 0);
            random_pixel_count++;
         end
      end
   endtask

   function automatic csr_data_type pick_width();
      int roll;
      roll = $urandom_range(99);
      if (roll < 10) return csr_data_type'($urandom_range(3));
      if (roll < 30) return csr_data_type'($urandom_range(40, 13));
      return csr_data_type'($urandom_range(12, 3));
   endfunction

   function automatic int pick_gap_pct();
      unique case ($urandom_range(3))
         0:       return 0;
         1:       return 5;
         2:       return 20;
         default: return 50;
      endcase
   endfunction

   initial begin : stimulus
      csr_data_type w_val, h_val;
      logic         k_val;
      logic [2:0]   sel;

      // drive every input to a known value, then hold reset
      reset                = 1'b1;
      pixel_if.valid       = 1'b0;
      pixel_if.pixel       = '0;
      pixel_if.frame_start = 1'b0;
      result_if.ready      = 1'b0;
      csr_if.valid         = 1'b0;
      csr_if.index         = CSR_FRAME_WIDTH;
      csr_if.data          = '0;
      send_gap_pct         = 20;
      take_gap_pct         = 20;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: width and height below the minimum clamp to 3x3 frames
      program_registers(3'b111, '0, '0, KERNEL_LAPLACIAN);
      queue_window(8'hFF, 8'h00, 8'h00, 1'b1);
      queue_pixel(8'h55, 1'b0);
      queue_pixel(8'hAA, 1'b0);
      queue_window(8'h00, 8'hFF, 8'hFF, 1'b1);
      drain_stream();
      program_registers(3'b100, '0, '0, KERNEL_SHARPEN);
      queue_window(8'hFF, 8'h00, 8'hFF, 1'b0);
      drain_stream();

      // widest setting: sizes above the maximum clamp, a short first row gives no sums
      send_gap_pct = 10;
      program_registers(3'b111, 11'h7FF, 11'h7FF, logic'($urandom_range(1)));
      for (int i = 0; i < WIDE_PIXELS; i++)
         queue_pixel(pixel_type'($urandom_range(255)), i == 0);
      drain_stream();

      // fill both line stores across the widest random frame, stop in the middle of row 2
      program_registers(3'b011, csr_data_type'(FILL_WIDTH), csr_data_type'(FILL_HEIGHT),
                        KERNEL_LAPLACIAN);
      for (int i = 0; i < 2 * FILL_WIDTH + FILL_WIDTH / 2; i++)
         queue_pixel(pixel_type'($urandom_range(255)), i == 0);
      drain_stream();

      // shrink the size mid-frame so column and row both wrap, and stall the receiver
      send_gap_pct = 0;
      take_gap_pct = 0;
      gen_width    = 8;
      gen_height   = 3;
      program_registers(3'b011, csr_data_type'(gen_width), csr_data_type'(gen_height),
                        KERNEL_LAPLACIAN);
      for (int i = 0; i < 150; i++)
         queue_pixel(pixel_type'($urandom_range(255)), 1'b0);
      pressure_armed = 1'b1;
      drain_stream();

      // random phases; reprogram between them, often in the middle of a frame
      random_pixel_count = 0;
      while (random_pixel_count < RANDOM_PIXELS) begin
         if (random_pixel_count >= QUIET_TAIL_FROM) begin
            send_gap_pct = 0;
            take_gap_pct = 0;
         end else begin
            send_gap_pct = pick_gap_pct();
            take_gap_pct = pick_gap_pct();
         end
         sel   = 3'($urandom_range(7, 1));
         w_val = pick_width();
         h_val = ($urandom_range(99) < 10) ? csr_data_type'($urandom_range(2))
                                           : csr_data_type'($urandom_range(8, 3));
         k_val = logic'($urandom_range(1));
         program_registers(sel, w_val, h_val, k_val);
         if (sel[0]) gen_width = clamp_dim(w_val, MAX_WIDTH);
         if (sel[1]) gen_height = clamp_dim(h_val, MAX_HEIGHT);
         queue_random_frames();
         drain_stream();
      end

      if (mismatch_count == 0 && sums_in_flight.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule : tb_conv3x3_edge_sharpen_filter_top

`default_nettype wire
